FILE: design/htk_pkg.sv
`default_nettype none

package htk_pkg;

   localparam int QueueDepth = 2;
   localparam int NumMethods = 9;

   localparam logic [3:0] CODE_NONE = 4'd9;

   typedef enum logic [2:0] {
      KIND_METHOD = 3'd0,
      KIND_URI    = 3'd1,
      KIND_NAME   = 3'd2,
      KIND_VALUE  = 3'd3,
      KIND_DROP   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      PH_METHOD   = 3'd0,
      PH_URI      = 3'd1,
      PH_LINE_END = 3'd2,
      PH_NAME     = 3'd3,
      PH_VALUE    = 3'd4,
      PH_STOPPED  = 3'd5
   } phase_type;

   // classified request byte
   typedef struct packed {
      logic [7:0] data;
      logic       start;
      logic       is_nul;
      logic       is_space;
      logic       is_cr;
      logic       is_lf;
      logic       is_colon;
   } item_type;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       field_end;
      logic [3:0] method_code;
      logic       parse_error;
   } result_type;

   // GET HEAD POST PUT DELETE CONNECT OPTIONS TRACE PATCH, zero padded
   localparam logic [7:0] METHOD_CHARS [NumMethods][8] = '{
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
      '{"C", "O", "N", "N", "E", "C", "T", 8'h00},
      '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
      '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
      '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00}
   };

   localparam logic [2:0] METHOD_LENS [NumMethods] = '{
      3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd7, 3'd5, 3'd5
   };

   function automatic logic [NumMethods-1:0] method_keep(input logic [3:0] count,
                                                          input logic [7:0] b);
      logic [NumMethods-1:0] keep;
      keep = '0;
      for (int i = 0; i < NumMethods; i++) begin
         keep[i] = (count < {1'b0, METHOD_LENS[i]}) && (METHOD_CHARS[i][count[2:0]] == b);
      end
      return keep;
   endfunction

   // lowest matching index wins
   function automatic logic [3:0] method_finish(input logic [NumMethods-1:0] mask,
                                                input logic [3:0] count);
      logic [3:0] code;
      code = CODE_NONE;
      for (int i = NumMethods - 1; i >= 0; i--) begin
         if (mask[i] && (count == {1'b0, METHOD_LENS[i]})) begin
            code = 4'(i);
         end
      end
      return code;
   endfunction

endpackage

`default_nettype wire

FILE: design/htk_front.sv
`default_nettype none

module htk_front (
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_start_of_request,
   input  wire logic              queue_full,
   output logic                   push,
   output htk_pkg::item_type      push_item
);

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.data     = req_data_byte;
      push_item.start    = req_start_of_request;
      push_item.is_nul   = (req_data_byte == 8'h00);
      push_item.is_space = (req_data_byte == " ");
      push_item.is_cr    = (req_data_byte == 8'h0d);
      push_item.is_lf    = (req_data_byte == 8'h0a);
      push_item.is_colon = (req_data_byte == ":");
   end

endmodule

`default_nettype wire

FILE: design/htk_queue.sv
`default_nettype none

module htk_queue #(
   parameter int Depth = htk_pkg::QueueDepth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire htk_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output htk_pkg::item_type      pop_item
);

   localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   htk_pkg::item_type entries_ff [Depth];
   logic [IdxW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign pop_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: design/htk_back.sv
`default_nettype none

module htk_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              queue_empty,
   input  wire htk_pkg::item_type pop_item,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_data_out,
   output logic [2:0]             rsp_byte_kind,
   output logic                   rsp_field_end,
   output logic [3:0]             rsp_method_code,
   output logic                   rsp_parse_error
);

   localparam int NM = htk_pkg::NumMethods;

   htk_pkg::phase_type  phase_ff, phase_in, phase_cur;
   logic [NM-1:0]       mask_ff, mask_in, mask_cur;
   logic [3:0]          count_ff, count_in, count_cur;
   logic                started_ff, started_in, started_cur;
   logic                after_cr_ff, after_cr_in, after_cr_cur;
   logic [3:0]          code_fin;
   htk_pkg::result_type res_ff, res_in;
   logic                out_valid_ff, out_valid_in;

   assign pop = !queue_empty && (!out_valid_ff || !rsp_stall);

   // start flag clears everything before the byte is taken
   always_comb begin
      if (pop_item.start) begin
         phase_cur    = htk_pkg::PH_METHOD;
         mask_cur     = '1;
         count_cur    = '0;
         started_cur  = 1'b0;
         after_cr_cur = 1'b0;
      end else begin
         phase_cur    = phase_ff;
         mask_cur     = mask_ff;
         count_cur    = count_ff;
         started_cur  = started_ff;
         after_cr_cur = after_cr_ff;
      end
   end

   assign code_fin = htk_pkg::method_finish(mask_cur, count_cur);

   always_comb begin
      phase_in    = phase_ff;
      mask_in     = mask_ff;
      count_in    = count_ff;
      started_in  = started_ff;
      after_cr_in = after_cr_ff;

      res_in.data        = pop_item.data;
      res_in.kind        = htk_pkg::KIND_DROP;
      res_in.field_end   = 1'b0;
      res_in.method_code = htk_pkg::CODE_NONE;
      res_in.parse_error = 1'b0;

      if (pop) begin
         phase_in    = phase_cur;
         mask_in     = mask_cur;
         count_in    = count_cur;
         started_in  = started_cur;
         after_cr_in = after_cr_cur;

         if (pop_item.is_nul && (phase_cur != htk_pkg::PH_STOPPED)) begin
            phase_in = htk_pkg::PH_STOPPED;
         end else begin
            unique case (phase_cur)
               htk_pkg::PH_METHOD: begin
                  if (pop_item.is_space) begin
                     res_in.field_end   = 1'b1;
                     res_in.method_code = code_fin;
                     if (code_fin == htk_pkg::CODE_NONE) begin
                        res_in.parse_error = 1'b1;
                        phase_in           = htk_pkg::PH_STOPPED;
                     end else begin
                        phase_in = htk_pkg::PH_URI;
                     end
                  end else begin
                     res_in.kind = htk_pkg::KIND_METHOD;
                     mask_in     = mask_cur & htk_pkg::method_keep(count_cur, pop_item.data);
                     count_in    = (count_cur == 4'hf) ? count_cur : count_cur + 4'd1;
                  end
               end
               htk_pkg::PH_URI: begin
                  if (pop_item.is_space) begin
                     res_in.field_end = 1'b1;
                     phase_in         = htk_pkg::PH_LINE_END;
                  end else begin
                     res_in.kind = htk_pkg::KIND_URI;
                  end
               end
               htk_pkg::PH_LINE_END: begin
                  if (pop_item.is_lf) begin
                     phase_in = htk_pkg::PH_NAME;
                  end
               end
               htk_pkg::PH_NAME: begin
                  if (after_cr_cur && pop_item.is_lf) begin
                     res_in.kind = htk_pkg::KIND_DROP;
                  end else if (pop_item.is_colon) begin
                     phase_in   = htk_pkg::PH_VALUE;
                     started_in = 1'b0;
                  end else begin
                     res_in.kind = htk_pkg::KIND_NAME;
                  end
                  after_cr_in = 1'b0;
               end
               htk_pkg::PH_VALUE: begin
                  if (pop_item.is_cr || pop_item.is_lf) begin
                     res_in.field_end = 1'b1;
                     after_cr_in      = pop_item.is_cr;
                     started_in       = 1'b0;
                     phase_in         = htk_pkg::PH_NAME;
                  end else if (!pop_item.is_space || started_cur) begin
                     res_in.kind = htk_pkg::KIND_VALUE;
                     started_in  = 1'b1;
                  end
               end
               default: begin
                  res_in.kind = htk_pkg::KIND_DROP;
               end
            endcase
         end
      end
   end

   assign out_valid_in = pop || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= htk_pkg::PH_METHOD;
         mask_ff      <= '1;
         count_ff     <= '0;
         started_ff   <= 1'b0;
         after_cr_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         mask_ff      <= mask_in;
         count_ff     <= count_in;
         started_ff   <= started_in;
         after_cr_ff  <= after_cr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_data_out    = res_ff.data;
   assign rsp_byte_kind   = res_ff.kind;
   assign rsp_field_end   = res_ff.field_end;
   assign rsp_method_code = res_ff.method_code;
   assign rsp_parse_error = res_ff.parse_error;

   a_error_closes_method: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parse_error |->
         rsp_field_end && (rsp_method_code == htk_pkg::CODE_NONE))
      else $error("parse error without method close");

   a_code_on_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_method_code != htk_pkg::CODE_NONE) |->
         rsp_field_end && (rsp_data_out == " ") && (rsp_byte_kind == htk_pkg::KIND_DROP))
      else $error("method code off the closing space");

   a_stopped_drops: assert property (@(posedge clock) disable iff (reset)
      pop && !pop_item.start && (phase_ff == htk_pkg::PH_STOPPED) |=>
         rsp_valid && (rsp_byte_kind == htk_pkg::KIND_DROP) && !rsp_field_end)
      else $error("stopped parser tagged a byte");

endmodule

`default_nettype wire

FILE: design/http_request_head_tokenizer.sv
`default_nettype none

// channel  direction  handshake          payload
// req      in         req_valid/stall    data_byte, start_of_request
// rsp      out        rsp_valid/stall    data_out, byte_kind, field_end, method_code,
//                                        parse_error
//
// one request in and one out per clock when the output side does not stall
// each byte passes through the queue and then into the output register
// the parser state update in the back end is the single-cycle loop that sets the rate
// synchronous reset returns the parser to the method phase and empties the queue
// output stalls fill the queue, after which req_stall rises

module http_request_head_tokenizer #(
   parameter int QueueDepth = htk_pkg::QueueDepth
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_start_of_request,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_data_out,
   output logic [2:0]      rsp_byte_kind,
   output logic            rsp_field_end,
   output logic [3:0]      rsp_method_code,
   output logic            rsp_parse_error
);

   htk_pkg::item_type push_item;
   htk_pkg::item_type pop_item;
   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_empty;

   htk_front u_front (
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_start_of_request (req_start_of_request),
      .queue_full           (queue_full),
      .push                 (push),
      .push_item            (push_item)
   );

   htk_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .pop_item  (pop_item)
   );

   htk_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .pop_item        (pop_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_out    (rsp_data_out),
      .rsp_byte_kind   (rsp_byte_kind),
      .rsp_field_end   (rsp_field_end),
      .rsp_method_code (rsp_method_code),
      .rsp_parse_error (rsp_parse_error)
   );

endmodule

`default_nettype wire

FILE: tb/http_request_head_tokenizer_tb.sv
`timescale 1ns / 100ps

typedef struct packed {
   logic       start;
   logic [7:0] data;
} head_byte_type;

class tag_scoreboard;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;

   string               method_words [9];
   htk_pkg::phase_type  parse_phase;
   logic [8:0]          word_mask;
   logic [3:0]          word_len;
   bit                  value_seen;
   bit                  value_cr;
   htk_pkg::result_type expected_tags [$];
   int                  mismatch_count;

   function new();
      method_words = '{"GET", "HEAD", "POST", "PUT", "DELETE",
                       "CONNECT", "OPTIONS", "TRACE", "PATCH"};
      mismatch_count = 0;
      restart();
   endfunction

   function void restart();
      parse_phase = htk_pkg::PH_METHOD;
      word_mask   = '1;
      word_len    = '0;
      value_seen  = 1'b0;
      value_cr    = 1'b0;
   endfunction

   function logic [3:0] method_lookup();
      logic [3:0] code;
      code = htk_pkg::CODE_NONE;
      for (int i = 8; i >= 0; i--) begin
         if (word_mask[i] && int'(word_len) == method_words[i].len()) begin
            code = 4'(i);
         end
      end
      return code;
   endfunction

   // works out the tag of one accepted request byte
   function void note_request(logic [7:0] b, logic s);
      htk_pkg::result_type tag;
      tag.data        = b;
      tag.kind        = htk_pkg::KIND_DROP;
      tag.field_end   = 1'b0;
      tag.method_code = htk_pkg::CODE_NONE;
      tag.parse_error = 1'b0;
      if (s) begin
         restart();
      end
      if (b == CH_NUL && parse_phase != htk_pkg::PH_STOPPED) begin
         parse_phase = htk_pkg::PH_STOPPED;
      end else begin
         case (parse_phase)
            htk_pkg::PH_METHOD: begin
               if (b == CH_SPACE) begin
                  tag.field_end   = 1'b1;
                  tag.method_code = method_lookup();
                  if (tag.method_code == htk_pkg::CODE_NONE) begin
                     tag.parse_error = 1'b1;
                     parse_phase     = htk_pkg::PH_STOPPED;
                  end else begin
                     parse_phase = htk_pkg::PH_URI;
                  end
               end else begin
                  tag.kind = htk_pkg::KIND_METHOD;
                  for (int i = 0; i < 9; i++) begin
                     if (!(int'(word_len) < method_words[i].len() &&
                           method_words[i][int'(word_len)] == b)) begin
                        word_mask[i] = 1'b0;
                     end
                  end
                  if (word_len != 4'd15) begin
                     word_len = word_len + 4'd1;
                  end
               end
            end
            htk_pkg::PH_URI: begin
               if (b == CH_SPACE) begin
                  tag.field_end = 1'b1;
                  parse_phase   = htk_pkg::PH_LINE_END;
               end else begin
                  tag.kind = htk_pkg::KIND_URI;
               end
            end
            htk_pkg::PH_LINE_END: begin
               if (b == CH_LF) begin
                  parse_phase = htk_pkg::PH_NAME;
               end
            end
            htk_pkg::PH_NAME: begin
               if (value_cr && b == CH_LF) begin
                  tag.kind = htk_pkg::KIND_DROP;
               end else if (b == CH_COLON) begin
                  parse_phase = htk_pkg::PH_VALUE;
                  value_seen  = 1'b0;
               end else begin
                  tag.kind = htk_pkg::KIND_NAME;
               end
               value_cr = 1'b0;
            end
            htk_pkg::PH_VALUE: begin
               if (b == CH_CR || b == CH_LF) begin
                  tag.field_end = 1'b1;
                  value_cr      = (b == CH_CR);
                  value_seen    = 1'b0;
                  parse_phase   = htk_pkg::PH_NAME;
               end else if (b != CH_SPACE || value_seen) begin
                  tag.kind   = htk_pkg::KIND_VALUE;
                  value_seen = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      expected_tags.insert(expected_tags.size(), tag);
   endfunction

   task report(string msg);
      if (mismatch_count < 100) begin
         $display("error at %0t: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   task check_response(logic [7:0] d, logic [2:0] k, logic fe, logic [3:0] mc, logic pe);
      htk_pkg::result_type want;
      if (expected_tags.size() == 0) begin
         report($sformatf("response with no request waiting, byte %02h", d));
         return;
      end
      want = expected_tags.pop_front();
      if (d !== want.data) begin
         report($sformatf("data_out %02h, expected %02h", d, want.data));
      end
      if (k !== want.kind) begin
         report($sformatf("byte_kind %0d, expected %0d (byte %02h)", k, want.kind, want.data));
      end
      if (fe !== want.field_end) begin
         report($sformatf("field_end %b, expected %b (byte %02h)", fe, want.field_end,
                          want.data));
      end
      if (mc !== want.method_code) begin
         report($sformatf("method_code %0d, expected %0d (byte %02h)", mc,
                          want.method_code, want.data));
      end
      if (pe !== want.parse_error) begin
         report($sformatf("parse_error %b, expected %b (byte %02h)", pe,
                          want.parse_error, want.data));
      end
   endtask

   function int waiting();
      return expected_tags.size();
   endfunction
endclass

module http_request_head_tokenizer_tb;

   localparam int          CYCLE_LIMIT = 200000;
   localparam int          PHASE_BYTES = 534;
   localparam logic [7:0]  CH_NUL      = 8'h00;
   localparam logic [7:0]  CH_LF       = 8'h0A;
   localparam logic [7:0]  CH_CR       = 8'h0D;
   localparam logic [7:0]  CH_SPACE    = 8'h20;
   localparam logic [7:0]  CH_COLON    = 8'h3A;
   localparam logic [7:0]  CH_DASH     = 8'h2D;

   logic       clock                = 1'b0;
   logic       reset                = 1'b1;
   logic       req_valid            = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte        = 8'h00;
   logic       req_start_of_request = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall            = 1'b0;
   logic [7:0] rsp_data_out;
   logic [2:0] rsp_byte_kind;
   logic       rsp_field_end;
   logic [3:0] rsp_method_code;
   logic       rsp_parse_error;

   int unsigned   cycle_count = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            method_turn = 0;
   head_byte_type stream [$];
   tag_scoreboard sb = new();

   http_request_head_tokenizer i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_start_of_request (req_start_of_request),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_data_out         (rsp_data_out),
      .rsp_byte_kind        (rsp_byte_kind),
      .rsp_field_end        (rsp_field_end),
      .rsp_method_code      (rsp_method_code),
      .rsp_parse_error      (rsp_parse_error)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_data_out, rsp_byte_kind, rsp_field_end, rsp_method_code,
                           rsp_parse_error);
      end
   end

   function automatic void push_byte(logic [7:0] b, logic s);
      head_byte_type item;
      item.start = s;
      item.data  = b;
      stream.insert(stream.size(), item);
   endfunction

   function automatic void push_text(string t, logic s);
      for (int i = 0; i < t.len(); i++) begin
         push_byte(t[i], (i == 0) ? s : 1'b0);
      end
   endfunction

   function automatic logic [7:0] rand_letter();
      return 8'h41 + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_name_char();
      if ($urandom_range(9) == 0) begin
         return CH_DASH;
      end
      return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'($urandom_range(25));
   endfunction

   // one request head: method, uri, version, headers, maybe a blank line, maybe body
   function automatic void add_request();
      int    first;
      int    pick;
      int    how;
      int    pos;
      int    n;
      string w;
      string version;
      first   = stream.size();
      version = "HTTP/1.1";
      pick    = $urandom_range(99);
      if (pick < 78) begin
         push_text(sb.method_words[method_turn], 1'b0);
         method_turn = (method_turn + 1) % 9;
      end else if (pick < 88) begin
         w   = sb.method_words[$urandom_range(8)];
         how = $urandom_range(2);
         pos = $urandom_range(w.len() - 1);
         for (int i = 0; i < w.len(); i++) begin
            if (!(how == 0 && i == w.len() - 1)) begin
               push_byte((how == 1 && i == pos) ? rand_letter() : w[i], 1'b0);
            end
         end
         if (how == 2) begin
            push_byte(rand_letter(), 1'b0);
         end
      end else if (pick < 95) begin
         n = $urandom_range(20, 1);
         for (int i = 0; i < n; i++) begin
            push_byte(rand_letter(), 1'b0);
         end
      end
      push_byte(CH_SPACE, 1'b0);
      n = $urandom_range(10);
      for (int i = 0; i < n; i++) begin
         push_byte(8'($urandom_range(8'h7E, 8'h21)), 1'b0);
      end
      push_byte(CH_SPACE, 1'b0);
      n = $urandom_range(8);
      for (int i = 0; i < n; i++) begin
         push_byte(version[i], 1'b0);
      end
      if ($urandom_range(99) < 80) begin
         push_byte(CH_CR, 1'b0);
      end
      push_byte(CH_LF, 1'b0);
      n = $urandom_range(2);
      for (int h = 0; h < n; h++) begin
         how = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
         for (int i = 0; i < how; i++) begin
            push_byte(rand_name_char(), 1'b0);
         end
         push_byte(CH_COLON, 1'b0);
         how = $urandom_range(3);
         for (int i = 0; i < how; i++) begin
            push_byte(CH_SPACE, 1'b0);
         end
         how = $urandom_range(6);
         for (int i = 0; i < how; i++) begin
            push_byte(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
         end
         pick = $urandom_range(99);
         if (pick < 85) begin
            push_byte((pick < 70) ? CH_CR : CH_LF, 1'b0);
         end
         if (pick < 70) begin
            push_byte(CH_LF, 1'b0);
         end else if (pick >= 85) begin
            push_byte(CH_CR, 1'b0);
         end
      end
      if ($urandom_range(99) < 80) begin
         push_byte(CH_CR, 1'b0);
         push_byte(CH_LF, 1'b0);
      end
      if ($urandom_range(99) < 25) begin
         n = $urandom_range(6, 1);
         for (int i = 0; i < n; i++) begin
            push_byte(8'($urandom_range(255, 1)), 1'b0);
         end
      end
      if ($urandom_range(99) < 8) begin
         stream[$urandom_range(stream.size() - 1, first)].data = CH_NUL;
      end
      if ($urandom_range(99) < 95) begin
         stream[first].start = 1'b1;
      end
   endfunction

   function automatic void add_noise();
      int n;
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++) begin
         push_byte(8'($urandom_range(255)), ($urandom_range(3) == 0));
      end
   endfunction

   // entered and left at a falling edge
   task automatic send_byte(head_byte_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_data_byte        <= item.data;
      req_start_of_request <= item.start;
      do @(posedge clock); while (req_stall);
      sb.note_request(item.data, item.start);
      @(negedge clock);
   endtask

   task automatic send_stream();
      while (stream.size() > 0) begin
         send_byte(stream.pop_front());
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.waiting() != 0);
   endtask

   initial begin
      int sent;
      repeat (12) @(negedge clock);
      reset         <= 1'b0;
      send_idle_pct = 38;
      recv_idle_pct = 65;

      // request line end, leading value spaces, lf after cr, nul, empty and unknown method
      push_text("PUT / x", 1'b1);
      push_byte(CH_LF, 1'b0);
      push_text("A:  v", 1'b0);
      push_byte(CH_CR, 1'b0);
      push_byte(CH_LF, 1'b0);
      push_byte(CH_NUL, 1'b0);
      push_byte(8'h7A, 1'b0);
      push_byte(CH_SPACE, 1'b1);
      push_byte(8'h51, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(CH_SPACE, 1'b0);
      send_stream();
      drain();

      for (int phase_idx = 0; phase_idx < 3; phase_idx++) begin
         send_idle_pct = (phase_idx == 0) ? 38 : (phase_idx == 1) ? 65 : 0;
         recv_idle_pct = (phase_idx == 0) ? 65 : (phase_idx == 1) ? 38 : 0;
         sent          = 0;
         while (sent < PHASE_BYTES) begin
            if ($urandom_range(99) < 85) begin
               add_request();
            end else begin
               add_noise();
            end
            sent += stream.size();
            send_stream();
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (sb.mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
